// ===== hw/rtl/ocd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the oracle commitment decoder
// no dependencies; used by all ocd modules
package ocd_pkg;

  localparam logic [7:0] HdrFirst    = 8'h6a;
  localparam logic [7:0] HdrSecond   = 8'hbf;
  localparam logic [7:0] OpPushData1 = 8'h4c;
  localparam logic [7:0] OpPushData2 = 8'h4d;
  localparam logic [7:0] OpPushData4 = 8'h4e;
  localparam logic [7:0] WantVersion = 8'h03;
  localparam logic [8:0] MinPayload  = 9'd87;
  localparam logic [8:0] CountCap    = 9'd342;
  localparam logic [8:0] FixedBytes  = 9'd86;

  // parse phase, one-hot
  typedef enum logic [6:0] {
    PH_HDR1   = 7'b0000001,
    PH_HDR2   = 7'b0000010,
    PH_OPCODE = 7'b0000100,
    PH_LEN1   = 7'b0001000,
    PH_LEN2   = 7'b0010000,
    PH_LEN4   = 7'b0100000,
    PH_DATA   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [7:0] script_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic               valid_res;
    logic [7:0]         participants;
    logic [31:0]        epoch;
    logic [63:0]        price;
    logic signed [63:0] stamp;
  } res_item_t;

  // handshake between input stage, parser and output stage
  typedef struct packed {
    logic step;   // input register item consumed this cycle
    logic emit;   // a result is loaded into the output register
  } flow_t;

  function automatic logic [7:0] popcount8(input logic [7:0] b);
    logic [7:0] n;
    n = 8'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {7'd0, b[i]};
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/ocd_byte_if.sv =====
`timescale 1ns / 1ps
// script byte channel: valid/ready plus one script byte and its last mark
// no dependencies
interface ocd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       last;

  modport source (output valid, output script_byte, output last, input ready);
  modport sink (input valid, input script_byte, input last, output ready);
endinterface

// ===== hw/rtl/ocd_res_if.sv =====
`timescale 1ns / 1ps
// result channel: valid/ready plus the decoded commitment fields
// no dependencies
interface ocd_res_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [7:0]         participants;
  logic [31:0]        epoch;
  logic [63:0]        price;
  logic signed [63:0] stamp;

  modport source (output valid, output valid_res, output participants, output epoch,
                  output price, output stamp, input ready);
  modport sink (input valid, input valid_res, input participants, input epoch,
                input price, input stamp, output ready);
endinterface

// ===== hw/rtl/ocd_in_stage.sv =====
`timescale 1ns / 1ps
// input register of the decoder: holds one script byte until the parser takes it
// depends on ocd_pkg and ocd_byte_if
module ocd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  ocd_byte_if.sink            byte_i,
  input  ocd_pkg::flow_t      flow_i,
  output logic                vld_o,
  output ocd_pkg::byte_item_t item_o
);

  logic                vld_q, vld_d;
  ocd_pkg::byte_item_t item_q, item_d;
  logic                take;

  assign byte_i.ready = !vld_q || flow_i.step;
  assign take         = byte_i.valid && byte_i.ready;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (take) begin
      vld_d              = 1'b1;
      item_d.script_byte = byte_i.script_byte;
      item_d.last        = byte_i.last;
    end else if (flow_i.step) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== hw/rtl/ocd_parser.sv =====
`timescale 1ns / 1ps
// push parser and payload field decoder, one script byte per step
// depends on ocd_pkg
module ocd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ocd_pkg::flow_t      flow_i,
  input  ocd_pkg::byte_item_t item_i,
  output ocd_pkg::res_item_t  res_o
);

  ocd_pkg::phase_e phase_q, phase_d;
  logic [1:0]  left_q, left_d;
  logic [31:0] push_q, push_d;
  logic [8:0]  count_q, count_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  bmlen_q, bmlen_d;
  logic [7:0]  bits_q, bits_d;
  logic [31:0] epoch_q, epoch_d;
  logic [63:0] price_q, price_d;
  logic [63:0] stamp_q, stamp_d;
  logic        failed_q, failed_d;

  logic [7:0]  b;
  logic [1:0]  pos;
  logic [31:0] push_or;
  logic [8:0]  p_off;
  logic [8:0]  q_off;
  logic [8:0]  q_price;
  logic [8:0]  q_stamp;
  logic        ok;

  assign b       = item_i.script_byte;
  assign p_off   = count_q - 9'd2;
  assign q_off   = p_off - {1'b0, bmlen_q};
  assign q_price = q_off - 9'd4;
  assign q_stamp = q_off - 9'd12;

  // byte lane of the length field being read
  always_comb begin
    case (phase_q)
      ocd_pkg::PH_LEN2: pos = 2'd1 - left_q;
      ocd_pkg::PH_LEN4: pos = 2'd3 - left_q;
      default:          pos = 2'd0;
    endcase
    push_or = push_q | ({24'd0, b} << {pos, 3'b000});
  end

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    push_d    = push_q;
    count_d   = count_q;
    version_d = version_q;
    bmlen_d   = bmlen_q;
    bits_d    = bits_q;
    epoch_d   = epoch_q;
    price_d   = price_q;
    stamp_d   = stamp_q;
    failed_d  = failed_q;
    if (!failed_q) begin
      case (phase_q)
        ocd_pkg::PH_HDR1: begin
          if (b == ocd_pkg::HdrFirst) phase_d = ocd_pkg::PH_HDR2;
          else failed_d = 1'b1;
        end
        ocd_pkg::PH_HDR2: begin
          if (b == ocd_pkg::HdrSecond) phase_d = ocd_pkg::PH_OPCODE;
          else failed_d = 1'b1;
        end
        ocd_pkg::PH_OPCODE: begin
          push_d = 32'd0;
          if (b < ocd_pkg::OpPushData1) begin
            // opcode zero is an empty push
            if (b != 8'd0) begin
              push_d  = {24'd0, b};
              phase_d = ocd_pkg::PH_DATA;
            end
          end else if (b == ocd_pkg::OpPushData1) begin
            phase_d = ocd_pkg::PH_LEN1;
            left_d  = 2'd0;
          end else if (b == ocd_pkg::OpPushData2) begin
            phase_d = ocd_pkg::PH_LEN2;
            left_d  = 2'd1;
          end else if (b == ocd_pkg::OpPushData4) begin
            phase_d = ocd_pkg::PH_LEN4;
            left_d  = 2'd3;
          end else begin
            failed_d = 1'b1;
          end
        end
        ocd_pkg::PH_LEN1, ocd_pkg::PH_LEN2, ocd_pkg::PH_LEN4: begin
          push_d = push_or;
          if (left_q == 2'd0) begin
            phase_d = (push_or == 32'd0) ? ocd_pkg::PH_OPCODE : ocd_pkg::PH_DATA;
          end else begin
            left_d = left_q - 2'd1;
          end
        end
        ocd_pkg::PH_DATA: begin
          if (count_q == 9'd0) begin
            version_d = b;
          end else if (count_q == 9'd1) begin
            bmlen_d = b;
          end else if (p_off < {1'b0, bmlen_q}) begin
            bits_d = bits_q + ocd_pkg::popcount8(b);
          end else if (q_off < 9'd4) begin
            epoch_d = epoch_q | ({24'd0, b} << {q_off[1:0], 3'b000});
          end else if (q_off < 9'd12) begin
            price_d = price_q | ({56'd0, b} << {q_price[2:0], 3'b000});
          end else if (q_off < 9'd20) begin
            stamp_d = stamp_q | ({56'd0, b} << {q_stamp[2:0], 3'b000});
          end
          if (count_q < ocd_pkg::CountCap) count_d = count_q + 9'd1;
          push_d = push_q - 32'd1;
          if (push_d == 32'd0) phase_d = ocd_pkg::PH_OPCODE;
        end
        default: failed_d = 1'b1;
      endcase
    end
  end

  // verdict on the state after this byte
  assign ok = !failed_d && (phase_d == ocd_pkg::PH_OPCODE) &&
              (version_d == ocd_pkg::WantVersion) && (bmlen_d != 8'd0) &&
              (count_d >= ocd_pkg::MinPayload) &&
              (count_d == ocd_pkg::FixedBytes + {1'b0, bmlen_d}) &&
              (price_d != 64'd0);

  always_comb begin
    res_o.valid_res    = ok;
    res_o.participants = ok ? bits_d : 8'd0;
    res_o.epoch        = ok ? epoch_d : 32'd0;
    res_o.price        = ok ? price_d : 64'd0;
    res_o.stamp        = ok ? $signed(stamp_d) : 64'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ocd_pkg::PH_HDR1;
      left_q    <= 2'd0;
      push_q    <= 32'd0;
      count_q   <= 9'd0;
      version_q <= 8'd0;
      bmlen_q   <= 8'd0;
      bits_q    <= 8'd0;
      epoch_q   <= 32'd0;
      price_q   <= 64'd0;
      stamp_q   <= 64'd0;
      failed_q  <= 1'b0;
    end else if (flow_i.step) begin
      if (item_i.last) begin
        phase_q   <= ocd_pkg::PH_HDR1;
        left_q    <= 2'd0;
        push_q    <= 32'd0;
        count_q   <= 9'd0;
        version_q <= 8'd0;
        bmlen_q   <= 8'd0;
        bits_q    <= 8'd0;
        epoch_q   <= 32'd0;
        price_q   <= 64'd0;
        stamp_q   <= 64'd0;
        failed_q  <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        left_q    <= left_d;
        push_q    <= push_d;
        count_q   <= count_d;
        version_q <= version_d;
        bmlen_q   <= bmlen_d;
        bits_q    <= bits_d;
        epoch_q   <= epoch_d;
        price_q   <= price_d;
        stamp_q   <= stamp_d;
        failed_q  <= failed_d;
      end
    end
  end

endmodule

// ===== hw/rtl/ocd_out_stage.sv =====
`timescale 1ns / 1ps
// result register of the decoder: holds one result item until the sink takes it
// depends on ocd_pkg and ocd_res_if
module ocd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ocd_pkg::flow_t     flow_i,
  input  ocd_pkg::res_item_t res_i,
  output logic               busy_o,
  ocd_res_if.source          res_o
);

  logic               vld_q, vld_d;
  ocd_pkg::res_item_t res_q;

  always_comb begin
    vld_d = vld_q;
    if (flow_i.emit) vld_d = 1'b1;
    else if (res_o.ready) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.emit) res_q <= res_i;
  end

  // a held result that is not taken this cycle blocks the next final byte
  assign busy_o = vld_q && !res_o.ready;

  assign res_o.valid        = vld_q;
  assign res_o.valid_res    = res_q.valid_res;
  assign res_o.participants = res_q.participants;
  assign res_o.epoch        = res_q.epoch;
  assign res_o.price        = res_q.price;
  assign res_o.stamp        = res_q.stamp;

endmodule

// ===== hw/rtl/oracle_commitment_decoder.sv =====
`timescale 1ns / 1ps
// top level of the oracle commitment decoder
// depends on ocd_pkg, ocd_byte_if, ocd_res_if, ocd_in_stage, ocd_parser, ocd_out_stage

// the decoder takes one output script as a stream of bytes, one byte per item,
// with last set on the final byte, and gives exactly one result item per script
// when that final byte is parsed. the script must open with 0x6a 0xbf, followed
// by direct pushes or pushdata1/2/4 pushes whose data are joined into a payload:
// version 0x03, bitmap length, bitmap, epoch, price and timestamp (little
// endian), then 64 signature bytes. valid_res is 1 only for a well formed
// commitment with nonzero price; otherwise all other result fields are zero.
// throughput is one script byte per clock cycle, including across script
// boundaries, except while a final byte waits for the output register; a
// result is registered as its final byte leaves the input register. the rate
// is set by the parse update, combinational between the two registers.
// while a result waits in the output register, non-final bytes keep flowing;
// only the next final byte waits until the result is taken.
module oracle_commitment_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  ocd_byte_if.sink  byte_i,
  ocd_res_if.source res_o
);

  ocd_pkg::flow_t      flow;
  ocd_pkg::byte_item_t item;
  ocd_pkg::res_item_t  res;
  logic                in_vld;
  logic                out_busy;

  // the held byte moves on unless it is a final byte and the result slot holds an untaken result
  assign flow.step = in_vld && !(item.last && out_busy);
  assign flow.emit = flow.step && item.last;

  // input register
  ocd_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .flow_i (flow),
    .vld_o  (in_vld),
    .item_o (item)
  );

  // parse state and field decode, one byte per step
  ocd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flow_i (flow),
    .item_i (item),
    .res_o  (res)
  );

  // result register
  ocd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flow_i (flow),
    .res_i  (res),
    .busy_o (out_busy),
    .res_o  (res_o)
  );

endmodule
